// File: hdl/thresholded_euclidean_distance_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thresholded Euclidean distance block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef THRESHOLDED_EUCLIDEAN_DISTANCE_TOP_ASSERT_SVH
`define THRESHOLDED_EUCLIDEAN_DISTANCE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TED_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ted assertion failed");
`define TED_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define TED_ASSERT(lbl, clk, rst_n, prop)
`define TED_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// File: hdl/ted_pkg.sv
// ----------------------------------------------------------------------------
// ted_pkg
// Widths and the beat type shared by the thresholded Euclidean distance block.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int unsigned CELL_W     = 16;
  localparam int unsigned PREC_W     = 16;
  localparam int unsigned SQ_W       = 2 * CELL_W;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned DIST_W     = SUM_W / 2;
  localparam int unsigned ROOT_STEPS = DIST_W;
  localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            last;
  } beat_t;

endpackage

// File: hdl/ted_in_if.sv
// ----------------------------------------------------------------------------
// ted_in_if
// Cell pair channel: valid/ready with two cells and a last flag.
// ----------------------------------------------------------------------------
interface ted_in_if;
  logic                     valid;
  logic                     ready;
  logic [ted_pkg::CELL_W-1:0] cell_a;
  logic [ted_pkg::CELL_W-1:0] cell_b;
  logic                     last_cell;

  modport source (output valid, output cell_a, output cell_b, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_a, input cell_b, input last_cell,
                  output ready);
endinterface

// File: hdl/ted_out_if.sv
// ----------------------------------------------------------------------------
// ted_out_if
// Distance channel: valid/ready with one Q12.12 distance.
// ----------------------------------------------------------------------------
interface ted_out_if;
  logic                       valid;
  logic                       ready;
  logic [ted_pkg::DIST_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

// File: hdl/ted_front.sv
// ----------------------------------------------------------------------------
// ted_front
// Accepts cell pairs, applies the dead zone and squares the difference.
// ----------------------------------------------------------------------------
module ted_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ted_pkg::PREC_W-1:0]  cfg_wdata_i,
  ted_in_if.sink                      in_i,
  output logic                        push_valid_o,
  output ted_pkg::beat_t              push_beat_o,
  input  logic                        push_ready_i
);
  import ted_pkg::*;

  logic [PREC_W-1:0] prec_q;
  logic              vld_q;
  logic [CELL_W-1:0] diff_q;
  logic              last_q;
  logic [CELL_W-1:0] diff;
  logic              hit;
  logic              accept;

  always_comb begin
    diff = (in_i.cell_a >= in_i.cell_b) ? (in_i.cell_a - in_i.cell_b)
                                        : (in_i.cell_b - in_i.cell_a);
    hit  = diff > prec_q;
  end

  assign in_i.ready = !vld_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prec_q <= cfg_wdata_i;
      end
      if (accept) begin
        vld_q <= 1'b1;
      end else if (push_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= hit ? diff : '0;
      last_q <= in_i.last_cell;
    end
  end

  assign push_valid_o     = vld_q;
  assign push_beat_o.sq   = SQ_W'(diff_q) * SQ_W'(diff_q);
  assign push_beat_o.last = last_q;

endmodule

// File: hdl/ted_fifo.sv
// ----------------------------------------------------------------------------
// ted_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
`include "thresholded_euclidean_distance_top_assert.svh"

module ted_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  ted_pkg::beat_t push_beat_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output ted_pkg::beat_t pop_beat_o,
  input  logic           pop_ready_i
);
  import ted_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  beat_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_beat_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_beat_i;
    end
  end

  `TED_ASSERT_MSG(a_fifo_bound, clk_i, rst_ni, (cnt_q <= CNT_W'(DEPTH)), "fifo overfilled")

endmodule

// File: hdl/ted_back.sv
// ----------------------------------------------------------------------------
// ted_back
// Saturating accumulator and bit-serial square root with output register.
// ----------------------------------------------------------------------------
`include "thresholded_euclidean_distance_top_assert.svh"

module ted_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  ted_pkg::beat_t pop_beat_i,
  output logic           pop_ready_o,
  ted_out_if.source      out_o
);
  import ted_pkg::*;

  typedef enum logic [2:0] {
    ST_ACC  = 3'b001,
    ST_ROOT = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  op_q;
  logic [DIST_W+1:0] rem_q;
  logic [DIST_W-1:0] root_q;
  logic [DIST_W-1:0] dist_q;
  logic              out_valid_q;

  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [DIST_W+3:0] rem_sh;
  logic [DIST_W+3:0] trial;
  logic [DIST_W+1:0] rem_d;
  logic [DIST_W-1:0] root_d;
  logic              pop;
  logic              out_free;

  assign pop_ready_o = state_q == ST_ACC;
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(pop_beat_i.sq);
    sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  // one root bit per step: restoring square root
  always_comb begin
    rem_sh = {rem_q, op_q[SUM_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = (DIST_W + 2)'(rem_sh - trial);
      root_d = {root_q[DIST_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[DIST_W+1:0];
      root_d = {root_q[DIST_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      step_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_ACC: begin
          if (pop) begin
            if (pop_beat_i.last) begin
              sum_q   <= '0;
              step_q  <= '0;
              state_q <= ST_ROOT;
            end else begin
              sum_q <= sum_sat;
            end
          end
        end
        ST_ROOT: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_ACC;
          end
        end
        default: begin
          state_q <= ST_ACC;
        end
      endcase
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC && pop && pop_beat_i.last) begin
      op_q   <= sum_sat;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_ROOT) begin
      op_q   <= {op_q[SUM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
    if (state_q == ST_DONE && out_free) begin
      dist_q <= root_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.distance = dist_q;

  `TED_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `TED_ASSERT(a_sum_cleared, clk_i, rst_ni, (pop && pop_beat_i.last) |=> (sum_q == '0))
  `TED_ASSERT(a_rem_bound, clk_i, rst_ni, (state_q == ST_ROOT) |-> (rem_q <= {root_q, 1'b0}))

endmodule

// File: hdl/thresholded_euclidean_distance_top.sv
// ----------------------------------------------------------------------------
// thresholded_euclidean_distance_top
// Dead-zone Euclidean distance over streamed cell pairs of two matrices.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one cell pair per beat (cell_a, cell_b: unsigned Q4.12) and
//   last_cell. Differences above the precision register are squared and
//   summed with saturation at 2^48-1. The beat with last_cell set closes the
//   matrix: out_o then carries one beat with the floor square root of the
//   sum (Q12.12), and the sum restarts at zero.
//   cfg_we_i/cfg_wdata_i write precision (Q4.12); write only while idle.
//   Throughput: one beat per cycle while cells stream and the queue has room.
//   A last cell occupies the back end for its 24 root steps, one bit each,
//   plus entry and hand-off; the queue of QUEUE_DEPTH beats absorbs the
//   first cells of the next matrix meanwhile. The last cell passes the front
//   register, the queue, the root steps and the output register to its distance.
//   Reset clears the sum, precision and all valid flags. When out_o stalls,
//   the distance holds in its output register, the back end waits, and
//   in_i.ready drops once the queue and front register are full.
// ----------------------------------------------------------------------------
module thresholded_euclidean_distance_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ted_pkg::PREC_W-1:0] cfg_wdata_i,
  ted_in_if.sink                     in_i,
  ted_out_if.source                  out_o
);
  import ted_pkg::*;

  logic  push_valid;
  logic  push_ready;
  beat_t push_beat;
  logic  pop_valid;
  logic  pop_ready;
  beat_t pop_beat;

  ted_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_beat_o  (push_beat),
    .push_ready_i (push_ready)
  );

  ted_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_beat_i  (push_beat),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_beat_o   (pop_beat),
    .pop_ready_i  (pop_ready)
  );

  ted_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_beat_i  (pop_beat),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
